// ===== design/calendar_date_stepper_core_macros.svh =====
// Assertion macros shared by the calendar date stepper RTL.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CALENDAR_DATE_STEPPER_CORE_MACROS_SVH
`define CALENDAR_DATE_STEPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cds_pkg.sv =====
// Package for the calendar date stepper: field widths, mode codes, result type
// and the leap-year and month-length functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int MODE_W  = 2;

    localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
    localparam logic [DAY_W-1:0]   LAST_DAY_DEC = 5'd31;

    // Inverse of 25 modulo 2**YEAR_W, and the largest image of a multiple of 25.
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BACK = 2'd2;

    typedef struct packed {
        logic               err;
        logic               leap;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_step_res;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = y * INV25;
        div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
        return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
    endfunction

    // Zero for a month code outside 1..12.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== design/cds_step.sv =====
// Next-date logic: applies one load, forward or back request to the held date.
// Depends on cds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cds_step
    import cds_pkg::*;
(
    input  wire logic [MODE_W-1:0]  i_mode,
    input  wire logic [DAY_W-1:0]   i_new_day,
    input  wire logic [MONTH_W-1:0] i_new_month,
    input  wire logic [YEAR_W-1:0]  i_new_year,
    input  wire logic [DAY_W-1:0]   i_day,
    input  wire logic [MONTH_W-1:0] i_month,
    input  wire logic [YEAR_W-1:0]  i_year,
    input  wire logic               i_leap,
    output t_step_res               o_res
);

    logic [YEAR_W-1:0]  w_cand_year;
    logic               w_cand_leap;
    logic [DAY_W-1:0]   w_cur_len;
    logic [DAY_W-1:0]   w_new_len;
    logic [MONTH_W-1:0] w_prev_month;
    logic               w_load_ok;

    always_comb begin
        case (i_mode)
            MODE_LOAD: w_cand_year = i_new_year;
            MODE_FWD:  w_cand_year = i_year + YEAR_W'(1);
            default:   w_cand_year = i_year - YEAR_W'(1);
        endcase
    end

    assign w_cand_leap  = is_leap(w_cand_year);
    assign w_cur_len    = month_days(i_month, i_leap);
    assign w_new_len    = month_days(i_new_month, w_cand_leap);
    assign w_prev_month = i_month - MONTH_W'(1);
    assign w_load_ok    = (i_new_year != '0) && (i_new_year <= MAX_YEAR)
                        && (w_new_len != '0) && (i_new_day != '0)
                        && (i_new_day <= w_new_len);

    always_comb begin
        o_res = '{err: 1'b0, leap: i_leap, year: i_year, month: i_month, day: i_day};
        unique case (i_mode)
            MODE_LOAD: begin
                if (w_load_ok) begin
                    o_res.day   = i_new_day;
                    o_res.month = i_new_month;
                    o_res.year  = i_new_year;
                    o_res.leap  = w_cand_leap;
                end else begin
                    o_res.err = 1'b1;
                end
            end
            MODE_FWD: begin
                if (i_day < w_cur_len) begin
                    o_res.day = i_day + DAY_W'(1);
                end else if (i_month < LAST_MONTH) begin
                    o_res.day   = DAY_W'(1);
                    o_res.month = i_month + MONTH_W'(1);
                end else if (i_year < MAX_YEAR) begin
                    o_res.day   = DAY_W'(1);
                    o_res.month = MONTH_W'(1);
                    o_res.year  = w_cand_year;
                    o_res.leap  = w_cand_leap;
                end else begin
                    o_res.err = 1'b1;
                end
            end
            MODE_BACK: begin
                if (i_day > DAY_W'(1)) begin
                    o_res.day = i_day - DAY_W'(1);
                end else if (i_month > MONTH_W'(1)) begin
                    o_res.month = w_prev_month;
                    o_res.day   = month_days(w_prev_month, i_leap);
                end else if (i_year > YEAR_W'(1)) begin
                    o_res.day   = LAST_DAY_DEC;
                    o_res.month = LAST_MONTH;
                    o_res.year  = w_cand_year;
                    o_res.leap  = w_cand_leap;
                end else begin
                    o_res.err = 1'b1;
                end
            end
            default: o_res.err = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/calendar_date_stepper_core.sv =====
// Calendar date stepper: holds a Gregorian date and takes one request beat per
// clock unless the result output stalls, one result beat each. A request is held in
// the input register, then the next-date logic updates the date registers and the
// result register together; the sustained rate of one beat per cycle is set by the
// path from the held date back into itself. Reset gives 1 January of year 1. A
// rejected request keeps the date and sets the error flag.
// Depends on cds_pkg, cds_step and calendar_date_stepper_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_date_stepper_core_macros.svh"

module calendar_date_stepper_core
    import cds_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // new_day[4:0], new_month[8:5], new_year[22:9]
    input  wire logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // day[4:0], month[8:5], year[22:9], leap_year[23]
    output logic             m_axis_tuser    // error[0]
);

    logic               r_in_valid;
    logic [MODE_W-1:0]  r_in_mode;
    logic [DAY_W-1:0]   r_in_day;
    logic [MONTH_W-1:0] r_in_month;
    logic [YEAR_W-1:0]  r_in_year;

    logic [DAY_W-1:0]   r_day;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;
    logic               r_leap;

    logic               r_out_valid;
    t_step_res          r_out;

    t_step_res          w_res;
    logic               w_adv;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    cds_step u_step (
        .i_mode      (r_in_mode),
        .i_new_day   (r_in_day),
        .i_new_month (r_in_month),
        .i_new_year  (r_in_year),
        .i_day       (r_day),
        .i_month     (r_month),
        .i_year      (r_year),
        .i_leap      (r_leap),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode  <= s_axis_tuser;
            r_in_day   <= s_axis_tdata[4:0];
            r_in_month <= s_axis_tdata[8:5];
            r_in_year  <= s_axis_tdata[22:9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= DAY_W'(1);
            r_month <= MONTH_W'(1);
            r_year  <= YEAR_W'(1);
            r_leap  <= 1'b0;
        end else if (w_adv) begin
            r_day   <= w_res.day;
            r_month <= w_res.month;
            r_year  <= w_res.year;
            r_leap  <= w_res.leap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.leap, r_out.year, r_out.month, r_out.day};
    assign m_axis_tuser  = r_out.err;

    `CDS_ASSERT_NEXT(a_err_keeps_date, w_adv && w_res.err,
        r_day == $past(r_day) && r_month == $past(r_month) && r_year == $past(r_year),
        "rejected request changed the date")
    `CDS_ASSERT_NOW(a_date_in_range, 1'b1,
        r_day != '0 && r_month != '0 && r_month <= LAST_MONTH
        && r_year != '0 && r_year <= MAX_YEAR,
        "held date out of range")
    `CDS_ASSERT_NOW(a_leap_tracks_year, 1'b1, r_leap == is_leap(r_year),
        "leap flag out of step with year")
    `CDS_ASSERT_NEXT(a_adv_gives_result, w_adv, r_out_valid,
        "processed request produced no result")

endmodule

`default_nettype wire
